[rtl/sha1_message_digest_assert.svh]
// ----------------------------------------------------------------------------
// sha1 message digest assertion macros
// shorthand for clocked properties on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SHA1MD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SHA1MD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sha1md_pkg.sv]
// ----------------------------------------------------------------------------
// sha1md_pkg
// types, constants and the control store of the sha1 message digest block
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  // step addresses of the control program
  typedef enum logic [3:0] {
    ST_WAIT,
    ST_PAD_DATA,
    ST_PAD_MARK,
    ST_PAD_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_EMIT,
    ST_LOAD,
    ST_ROUND,
    ST_ADD
  } step_t;

  // word pushed into the schedule line
  typedef enum logic [2:0] {
    SRC_IN,
    SRC_FINAL,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } push_src_t;

  // when a push happens
  typedef enum logic [2:0] {
    PC_NEVER,
    PC_DATA,
    PC_ALWAYS,
    PC_FULL_WORD,
    PC_FILL
  } push_cond_t;

  // datapath operation
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROUND,
    OP_ADD,
    OP_EMIT
  } dp_op_t;

  // sequencing of the step counter
  typedef enum logic [2:0] {
    SQ_GOTO,
    SQ_INPUT,
    SQ_FILL,
    SQ_ROUNDS,
    SQ_RETURN,
    SQ_OUT
  } seq_t;

  typedef struct packed {
    push_src_t  src;
    push_cond_t pcond;
    dp_op_t     op;
    seq_t       seq;
    step_t      next_a;
    step_t      next_b;
  } ucode_t;

  typedef struct packed {
    logic push;
    logic load;
    logic round;
    logic add;
    logic restart;
  } dp_ctrl_t;

  typedef struct packed {
    logic last_round;
  } dp_stat_t;

  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [3:0][31:0] SHA1_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [3:0] WORDS_LAST = 4'd15;
  localparam logic [3:0] LEN_SLOT   = 4'd14;
  localparam logic [2:0] NB_FULL    = 3'd4;

  // control store
  function automatic ucode_t ucode_rom(input step_t st);
    ucode_t u;
    unique case (st)
      ST_WAIT:     u = '{SRC_IN,     PC_DATA,      OP_NONE,  SQ_INPUT,  ST_WAIT,     ST_PAD_DATA};
      ST_PAD_DATA: u = '{SRC_FINAL,  PC_ALWAYS,    OP_NONE,  SQ_GOTO,   ST_PAD_MARK, ST_WAIT};
      ST_PAD_MARK: u = '{SRC_MARK,   PC_FULL_WORD, OP_NONE,  SQ_GOTO,   ST_PAD_ZERO, ST_WAIT};
      ST_PAD_ZERO: u = '{SRC_ZERO,   PC_FILL,      OP_NONE,  SQ_FILL,   ST_LEN_HI,   ST_WAIT};
      ST_LEN_HI:   u = '{SRC_LEN_HI, PC_ALWAYS,    OP_NONE,  SQ_GOTO,   ST_LEN_LO,   ST_WAIT};
      ST_LEN_LO:   u = '{SRC_LEN_LO, PC_ALWAYS,    OP_NONE,  SQ_GOTO,   ST_EMIT,     ST_WAIT};
      ST_EMIT:     u = '{SRC_ZERO,   PC_NEVER,     OP_EMIT,  SQ_OUT,    ST_WAIT,     ST_WAIT};
      ST_LOAD:     u = '{SRC_ZERO,   PC_NEVER,     OP_LOAD,  SQ_GOTO,   ST_ROUND,    ST_WAIT};
      ST_ROUND:    u = '{SRC_ZERO,   PC_NEVER,     OP_ROUND, SQ_ROUNDS, ST_ADD,      ST_WAIT};
      ST_ADD:      u = '{SRC_ZERO,   PC_NEVER,     OP_ADD,   SQ_RETURN, ST_WAIT,     ST_WAIT};
      default:     u = '{SRC_ZERO,   PC_NEVER,     OP_NONE,  SQ_GOTO,   ST_WAIT,     ST_WAIT};
    endcase
    return u;
  endfunction

  // keep the valid leading bytes of the final word and, when fewer than four are valid, append the marker byte
  function automatic logic [31:0] pad_final(input logic [31:0] word, input logic [2:0] nb);
    logic [31:0] r;
    unique case (nb)
      3'd0:    r = {PAD_BYTE, 24'h0};
      3'd1:    r = {word[31:24], PAD_BYTE, 16'h0};
      3'd2:    r = {word[31:16], PAD_BYTE, 8'h0};
      3'd3:    r = {word[31:8], PAD_BYTE};
      default: r = word;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sha1md_datapath.sv]
// ----------------------------------------------------------------------------
// sha1md_datapath
// schedule shift line, working variables, round logic and chaining value
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_datapath (
  input  wire                     clk,
  input  wire                     rst_n,
  input  sha1md_pkg::dp_ctrl_t    ctrl,
  input  wire  [31:0]             push_word,
  output sha1md_pkg::dp_stat_t    stat,
  output logic [159:0]            digest
);
  import sha1md_pkg::*;

  logic [31:0]      sched_r [16];
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [4:0][31:0] chain_r;
  logic [6:0]       t_r;

  logic [31:0] w_mix, w_new, shift_in, f, k, tmp;

  // sched_r holds w[t..t+15]; the next schedule word enters at the top
  assign w_mix    = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
  assign w_new    = {w_mix[30:0], w_mix[31]};
  assign shift_in = ctrl.push ? push_word : w_new;

  always_comb begin
    priority if (t_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = SHA1_K[0];
    end else if (t_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = SHA1_K[1];
    end else if (t_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = SHA1_K[2];
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = SHA1_K[3];
    end
  end

  assign tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + sched_r[0];

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.round) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i + 1];
      end
      sched_r[15] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctrl.round) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
    end else if (ctrl.load) begin
      t_r <= '0;
    end else if (ctrl.round) begin
      t_r <= t_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.restart) begin
      chain_r <= SHA1_IV;
    end else if (ctrl.add) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

  assign stat.last_round = (t_r == LAST_ROUND);
  assign digest          = chain_r;

endmodule

`default_nettype wire

[rtl/sha1_message_digest.sv]
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha1 hash of a byte message streamed as big-endian 32-bit words
// ----------------------------------------------------------------------------
// The message arrives four bytes to a transfer, first byte in bits 31..24.
// A transfer with in_tlast high ends the message and carries 0..4 valid
// leading bytes (a count above 4 counts as 4; on other transfers the count is
// ignored). An empty message is a last transfer with zero valid bytes. The
// block adds the 0x80 marker, the zero fill and the 64-bit bit length itself
// and then shows the 160-bit digest as one transfer on the out_ channel.
// Flow: a non-last word is pushed as it is taken; every sixteenth pushed word
// starts a compression (load, 80 rounds at one round per cycle, add), and no
// input is taken while it runs. After the last word the padding steps push
// one word per cycle outside compressions, up to 19 words counting the last
// word itself, plus one or two steps that push nothing; every block they fill
// costs another compression (two when the padding spills into a second
// block), and then the emit step loads the output register. The block is
// ready again once that is done; the emit step waits while the previous
// digest still sits unread in the output register. The digest waits in that
// register while the next message is already being taken.
// Control is a small microprogram: a step counter addresses a control store
// in the package, each step selects the pushed word, the datapath operation
// and the next step; compression is a subroutine entered whenever a push
// fills the block, with a one-entry return register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_message_digest_assert.svh"

module sha1_message_digest (
  input  wire          clk,
  input  wire          rst_n,
  // message input
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [39:0]  in_tdata,   // [31:0] message_word, [34:32] valid_bytes, rest zero
  input  wire          in_tlast,   // is_final
  // digest output
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [159:0] out_tdata   // [31:0] digest_word_0 .. [159:128] digest_word_4
);
  import sha1md_pkg::*;

  // sequencer state
  step_t       pc_r, pc_nxt;
  step_t       link_r, link_nxt;
  step_t       seq_next;
  logic [3:0]  words_r, words_nxt;
  logic [63:0] len_r, len_nxt;

  // last word and output register
  logic [31:0]  word_r;
  logic [2:0]   nb_r;
  logic         out_tvalid_r;
  logic [159:0] out_tdata_r;

  ucode_t      uc;
  logic        in_xfer;
  logic        out_free;
  logic        push;
  logic        block_full;
  logic        emit_go;
  logic [2:0]  nb_clamp;
  logic [31:0] push_word;
  dp_ctrl_t    dp_ctrl;
  dp_stat_t    dp_stat;
  logic [159:0] digest;

  assign uc        = ucode_rom(pc_r);
  assign in_tready = (pc_r == ST_WAIT);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign nb_clamp  = (in_tdata[34:32] > NB_FULL) ? NB_FULL : in_tdata[34:32];

  // push condition of the current step
  always_comb begin
    unique case (uc.pcond)
      PC_NEVER:     push = 1'b0;
      PC_DATA:      push = in_xfer && !in_tlast;
      PC_ALWAYS:    push = 1'b1;
      PC_FULL_WORD: push = (nb_r == NB_FULL);
      PC_FILL:      push = (words_r != LEN_SLOT);
      default:      push = 1'b0;
    endcase
  end

  // word pushed into the schedule line
  always_comb begin
    unique case (uc.src)
      SRC_IN:     push_word = in_tdata[31:0];
      SRC_FINAL:  push_word = pad_final(word_r, nb_r);
      SRC_MARK:   push_word = {PAD_BYTE, 24'h0};
      SRC_ZERO:   push_word = '0;
      SRC_LEN_HI: push_word = len_r[63:32];
      SRC_LEN_LO: push_word = len_r[31:0];
      default:    push_word = '0;
    endcase
  end

  // step sequencing
  always_comb begin
    unique case (uc.seq)
      SQ_GOTO:   seq_next = uc.next_a;
      SQ_INPUT:  seq_next = in_xfer ? (in_tlast ? uc.next_b : uc.next_a) : pc_r;
      SQ_FILL:   seq_next = (words_r == LEN_SLOT) ? uc.next_a : pc_r;
      SQ_ROUNDS: seq_next = dp_stat.last_round ? uc.next_a : pc_r;
      SQ_RETURN: seq_next = link_r;
      SQ_OUT:    seq_next = out_free ? uc.next_a : pc_r;
      default:   seq_next = uc.next_a;
    endcase
  end

  // a push that completes the block calls the compression routine
  assign block_full = push && (words_r == WORDS_LAST);
  assign emit_go    = (uc.op == OP_EMIT) && out_free;

  always_comb begin
    pc_nxt    = block_full ? ST_LOAD : seq_next;
    link_nxt  = block_full ? seq_next : link_r;
    words_nxt = words_r + {3'b000, push};
    len_nxt   = len_r;
    if (in_xfer && !in_tlast) begin
      len_nxt = len_r + 64'd32;
    end else if (in_xfer) begin
      len_nxt = len_r + {58'd0, nb_clamp, 3'b000};
    end else if (emit_go) begin
      len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_WAIT;
      link_r       <= ST_WAIT;
      words_r      <= '0;
      len_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      link_r  <= link_nxt;
      words_r <= words_nxt;
      len_r   <= len_nxt;
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // last word is held for the padding steps
  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      word_r <= in_tdata[31:0];
      nb_r   <= nb_clamp;
    end
    if (emit_go) begin
      out_tdata_r <= digest;
    end
  end

  assign dp_ctrl.push    = push;
  assign dp_ctrl.load    = (uc.op == OP_LOAD);
  assign dp_ctrl.round   = (uc.op == OP_ROUND);
  assign dp_ctrl.add     = (uc.op == OP_ADD);
  assign dp_ctrl.restart = emit_go;

  sha1md_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (dp_ctrl),
    .push_word (push_word),
    .stat      (dp_stat),
    .digest    (digest)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // a full block always enters compression next
  `SHA1MD_ASSERT_NEXT(a_full_calls_load, block_full, pc_r == ST_LOAD, "full block did not start compression")
  // the round step repeats until the last round
  `SHA1MD_ASSERT_NEXT(a_rounds_hold, pc_r == ST_ROUND && !dp_stat.last_round, pc_r == ST_ROUND, "round loop left early")
  // the length words close a block, so nothing is buffered at the output step
  `SHA1MD_ASSERT_NOW(a_emit_aligned, pc_r == ST_EMIT, words_r == 4'd0, "digest taken from a partial block")
  // emitting shows the digest and clears the message state
  `SHA1MD_ASSERT_NEXT(a_emit_restart, emit_go, out_tvalid_r && pc_r == ST_WAIT && len_r == 64'd0, "digest emit did not restart")

endmodule

`default_nettype wire
